// ===== rtl/gmp_pkg.sv =====
// Package for the grid max path sum block: field widths, size limits,
// the cell control struct and the saturating add used by every cell.
// No dependencies.
package gmp_pkg;

   localparam int CELL_W       = 16;
   localparam int SUM_W        = 28;
   localparam int CFG_W        = 7;
   localparam int MAX_SIZE_DEF = 64;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic first_row;
      logic lstart;
      logic rstart;
   } ctl_type;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [CELL_W-1:0] cval,
      input logic signed [SUM_W-1:0]  from
   );
      logic signed [SUM_W:0] s;
      s = (SUM_W+1)'(cval) + (SUM_W+1)'(from);
      if (s > (SUM_W+1)'(SUM_MAX)) begin
         return SUM_MAX;
      end else if (s < (SUM_W+1)'(SUM_MIN)) begin
         return SUM_MIN;
      end else begin
         return s[SUM_W-1:0];
      end
   endfunction

   function automatic logic signed [SUM_W-1:0] max_sum(
      input logic signed [SUM_W-1:0] a,
      input logic signed [SUM_W-1:0] b
   );
      return (a > b) ? a : b;
   endfunction

endpackage

// ===== rtl/gmp_ifs.sv =====
// Valid/ready channel interfaces for requests, responses and the size register.
// Depends on gmp_pkg.
interface gmp_req_if import gmp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CELL_W-1:0] cell_value;
   modport source (output valid, output cell_value, input ready);
   modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmp_rsp_if import gmp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] best_sum;
   modport source (output valid, output best_sum, input ready);
   modport sink   (input valid, input best_sum, output ready);
endinterface

interface gmp_csr_if import gmp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] grid_size;
   modport source (output valid, output grid_size, input ready);
   modport sink   (input valid, input grid_size, output ready);
endinterface

// ===== rtl/gmp_cell.sv =====
// One column cell: holds the column's cell value, left-pass sum and row best,
// and runs the left-to-right and right-to-left passes with its neighbors.
// Depends on gmp_pkg.
module gmp_cell
   import gmp_pkg::*;
#(
   parameter int IDX_W = 6,
   parameter int IDX   = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctl_type                  ctl,
   input  logic                     load_en,
   input  logic [IDX_W-1:0]         load_idx,
   input  logic signed [CELL_W-1:0] load_data,
   input  logic [IDX_W-1:0]         last_idx,
   input  logic                     left_tok,
   input  logic signed [SUM_W-1:0]  left_fl,
   input  logic                     right_tok,
   input  logic signed [SUM_W-1:0]  right_run,
   output logic                     tok_l,
   output logic signed [SUM_W-1:0]  fl,
   output logic                     tok_r,
   output logic signed [SUM_W-1:0]  run,
   output logic signed [SUM_W-1:0]  prev
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic                     tok_l_ff, tok_r_ff;
   logic                     tok_l_in, tok_r_in;
   logic signed [CELL_W-1:0] cell_ff, cell_in;
   logic signed [SUM_W-1:0]  fl_ff, fl_in;
   logic signed [SUM_W-1:0]  run_ff, run_in;
   logic signed [SUM_W-1:0]  prev_ff, prev_in;
   logic signed [SUM_W-1:0]  from_l, from_r, run_new;
   logic                     is_last;

   always_comb begin
      is_last  = (MY_IDX == last_idx);
      tok_l_in = left_tok;
      tok_r_in = right_tok | (ctl.rstart & is_last);

      if (MY_IDX == '0) begin
         from_l = ctl.first_row ? '0 : prev_ff;
      end else begin
         from_l = ctl.first_row ? left_fl : max_sum(left_fl, prev_ff);
      end
      from_r  = is_last ? prev_ff : max_sum(right_run, prev_ff);
      run_new = sat_add(cell_ff, from_r);

      cell_in = (load_en && load_idx == MY_IDX) ? load_data : cell_ff;
      fl_in   = fl_ff;
      run_in  = run_ff;
      prev_in = prev_ff;
      if (tok_l_in) begin
         fl_in = sat_add(cell_ff, from_l);
         if (ctl.first_row) begin
            prev_in = fl_in;
         end
      end else if (tok_r_in) begin
         run_in  = run_new;
         prev_in = max_sum(fl_ff, run_new);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_l_ff <= 1'b0;
         tok_r_ff <= 1'b0;
      end else begin
         tok_l_ff <= tok_l_in;
         tok_r_ff <= tok_r_in;
      end
      cell_ff <= cell_in;
      fl_ff   <= fl_in;
      run_ff  <= run_in;
      prev_ff <= prev_in;
   end

   assign tok_l = tok_l_ff;
   assign tok_r = tok_r_ff;
   assign fl    = fl_ff;
   assign run   = run_ff;
   assign prev  = prev_ff;

endmodule

// ===== rtl/gmp_ctrl.sv =====
// Sequencer: position counters, grid size register, pass timing and the
// response register. Depends on gmp_pkg.
module gmp_ctrl
   import gmp_pkg::*;
#(
   parameter int MAX_SIZE = MAX_SIZE_DEF,
   parameter int IDX_W    = 6,
   parameter int CNT_W    = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    csr_valid,
   input  logic [CFG_W-1:0]        csr_grid_size,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic signed [SUM_W-1:0] rsp_best_sum,
   input  logic signed [SUM_W-1:0] last_prev,
   output ctl_type                 ctl,
   output logic                    load_en,
   output logic [IDX_W-1:0]        load_idx,
   output logic [IDX_W-1:0]        last_idx
);

   typedef enum logic [1:0] {S_LOAD, S_LEFT, S_RIGHT, S_DONE} state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [IDX_W-1:0]        col_ff, col_in;
   logic [IDX_W-1:0]        row_ff, row_in;
   logic [IDX_W-1:0]        pcnt_ff, pcnt_in;
   logic                    lstart_ff, lstart_in;
   logic                    rstart_ff, rstart_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_data_ff, rsp_data_in;
   int                      g;

   assign last_idx = IDX_W'(n_ff - CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pcnt_in      = pcnt_ff;
      lstart_in    = 1'b0;
      rstart_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      g            = int'(csr_grid_size);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (col_ff == last_idx) begin
                  col_in    = '0;
                  pcnt_in   = '0;
                  lstart_in = 1'b1;
                  state_in  = S_LEFT;
               end else begin
                  col_in = col_ff + IDX_W'(1);
               end
            end
         end
         S_LEFT, S_RIGHT: begin
            if (pcnt_ff == last_idx) begin
               pcnt_in = '0;
               if (state_ff == S_LEFT && row_ff != '0) begin
                  rstart_in = 1'b1;
                  state_in  = S_RIGHT;
               end else if (row_ff == last_idx) begin
                  row_in   = '0;
                  state_in = S_DONE;
               end else begin
                  row_in   = row_ff + IDX_W'(1);
                  state_in = S_LOAD;
               end
            end else begin
               pcnt_in = pcnt_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = last_prev;
               state_in     = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase

      if (csr_valid) begin
         n_in   = (g == 0) ? CNT_W'(1) : (g > MAX_SIZE) ? CNT_W'(MAX_SIZE) : CNT_W'(g);
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         n_ff         <= CNT_W'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         pcnt_ff      <= '0;
         lstart_ff    <= 1'b0;
         rstart_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pcnt_ff      <= pcnt_in;
         lstart_ff    <= lstart_in;
         rstart_ff    <= rstart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready     = (state_ff == S_LOAD);
   assign load_en       = req_valid && req_ready;
   assign load_idx      = col_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_best_sum  = rsp_data_ff;
   assign ctl.first_row = (row_ff == '0);
   assign ctl.lstart    = lstart_ff;
   assign ctl.rstart    = rstart_ff;

endmodule

// ===== rtl/grid_max_path_sum_lrd_top.sv =====
// Top level of the grid max path sum block: sequencer plus a chain of column
// cells. Depends on gmp_pkg, gmp_ifs, gmp_cell and gmp_ctrl.
//
// Cells of an N by N grid (N = grid_size, 0 taken as 1, clamped to MAX_SIZE)
// are taken row-major, one request per cycle while a row loads. After the
// last cell of a row the cell chain runs a left-to-right pass and, from the
// second row on, a right-to-left pass, one column cell per cycle; requests
// are held off meanwhile. After the last row the sequencer enters its done
// state and then registers one response, the best sum to the bottom-right
// cell, once any earlier response has been taken; the next grid can load
// while it waits to be taken. Writing grid_size restarts the grid at its
// top-left cell; write it only while idle.
module grid_max_path_sum_lrd_top
   import gmp_pkg::*;
#(
   parameter int MAX_SIZE = MAX_SIZE_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gmp_req_if.sink   req,
   gmp_rsp_if.source rsp,
   gmp_csr_if.sink   csr
);

   localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int CNT_W = $clog2(MAX_SIZE + 1);

   ctl_type                 ctl;
   logic                    load_en;
   logic [IDX_W-1:0]        load_idx;
   logic [IDX_W-1:0]        last_idx;
   logic                    tok_l [MAX_SIZE+1];
   logic signed [SUM_W-1:0] fl    [MAX_SIZE+1];
   logic                    tok_r [MAX_SIZE+1];
   logic signed [SUM_W-1:0] run   [MAX_SIZE+1];
   logic signed [SUM_W-1:0] prev  [MAX_SIZE];
   logic signed [SUM_W-1:0] last_prev;

   assign csr.ready = 1'b1;

   gmp_ctrl #(
      .MAX_SIZE (MAX_SIZE),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_ready     (req.ready),
      .csr_valid     (csr.valid),
      .csr_grid_size (csr.grid_size),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .rsp_best_sum  (rsp.best_sum),
      .last_prev     (last_prev),
      .ctl           (ctl),
      .load_en       (load_en),
      .load_idx      (load_idx),
      .last_idx      (last_idx)
   );

   assign tok_l[0]        = ctl.lstart;
   assign fl[0]           = '0;
   assign tok_r[MAX_SIZE] = 1'b0;
   assign run[MAX_SIZE]   = '0;
   assign last_prev       = prev[last_idx];

   for (genvar j = 0; j < MAX_SIZE; j++) begin : g_cell
      gmp_cell #(
         .IDX_W (IDX_W),
         .IDX   (j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .load_en   (load_en),
         .load_idx  (load_idx),
         .load_data (req.cell_value),
         .last_idx  (last_idx),
         .left_tok  (tok_l[j]),
         .left_fl   (fl[j]),
         .right_tok (tok_r[j+1]),
         .right_run (run[j+1]),
         .tok_l     (tok_l[j+1]),
         .fl        (fl[j+1]),
         .tok_r     (tok_r[j]),
         .run       (run[j]),
         .prev      (prev[j])
      );
   end

endmodule
